// ----- src/tehq_pkg.sv -----
package tehq_pkg;

  localparam int Capacity = 32;
  localparam int TimeW = 32;
  localparam int HandleW = 5;
  localparam int NumHandles = 32;
  localparam int CountW = 6;
  localparam int AddrW = 5;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_QUEUED = 2'd2;
  localparam logic [1:0] ST_NOT_QUEUED = 2'd3;

  localparam logic [1:0] REG_WHOLE = 2'd0;
  localparam logic [1:0] REG_FRACTION = 2'd1;
  localparam logic [1:0] REG_DENOM = 2'd2;

  typedef struct packed {
    logic [TimeW-1:0] expiry;
    logic [HandleW-1:0] owner;
  } heap_entry_t;

  typedef struct packed {
    logic lt;
    logic le;
  } cmp_res_t;

endpackage

// ----- src/tehq_heap_ram.sv -----
module tehq_heap_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tehq_pkg::AddrW-1:0] waddr,
  input  tehq_pkg::heap_entry_t      wdata,
  input  logic [tehq_pkg::AddrW-1:0] raddr,
  output tehq_pkg::heap_entry_t      rdata
);
  import tehq_pkg::*;

  heap_entry_t mem [Capacity];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/tehq_rel_cmp.sv -----
module tehq_rel_cmp (
  input  logic [tehq_pkg::TimeW-1:0] now,
  input  logic [tehq_pkg::TimeW-1:0] a,
  input  logic [tehq_pkg::TimeW-1:0] b,
  output tehq_pkg::cmp_res_t         res
);
  import tehq_pkg::*;

  logic [TimeW-1:0] ra;
  logic [TimeW-1:0] rb;

  // Keys are distances ahead of the current time, so the order wraps.
  always_comb begin
    ra = a - now;
    rb = b - now;
    res.lt = ra < rb;
    res.le = ra <= rb;
  end

endmodule

// ----- src/timer_event_heap_queue.sv -----
// Insert climbs the heap one level at a time. Delete moves the tail entry up or
// down the heap level by level. Tick runs one delete per expired event;
// each expired beat is strobed as it pops and busy stays high to the end.
// One request at a time: the next is taken in the cycle of the closing beat.
// rst is synchronous: it empties the heap, clears the handle table and time,
// and resets the tick registers.
module timer_event_heap_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [4:0]  event_handle,
  input  logic [31:0] due_time,
  output logic        strobe,
  output logic [1:0]  status,
  output logic [4:0]  expired_handle,
  output logic        handle_valid,
  output logic        last,
  output logic [31:0] now_time,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tehq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_DEL_TAIL, S_DEL_KEY, S_DEL_PCMP, S_DEL_END,
    S_DN_RDL, S_DN_RDR, S_DN_SEL, S_DN_CMP, S_PLACE, S_TK_RD, S_TK_CMP, S_TK_FIN
  } state_t;

  state_t state;
  logic [CountW-1:0] handle_slot [NumHandles];
  logic [CountW-1:0] heap_count;
  logic [TimeW-1:0] now_reg;
  logic [TimeW-1:0] next_tick_time;
  logic [15:0] tick_remainder;
  logic [15:0] tick_whole;
  logic [15:0] tick_fraction;
  logic [15:0] tick_denominator;

  logic [CountW-1:0] pos;
  logic [TimeW-1:0] key;
  logic [HandleW-1:0] key_owner;
  logic [HandleW-1:0] del_h;
  logic del_mode;
  logic in_tick;
  logic [TimeW-1:0] child_exp;
  logic [HandleW-1:0] child_own;
  logic [CountW-1:0] child_idx;

  logic mem_we;
  logic [AddrW-1:0] mem_waddr;
  heap_entry_t mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  heap_entry_t mem_rdata;
  logic [TimeW-1:0] cmp_a;
  logic [TimeW-1:0] cmp_b;
  cmp_res_t cmp;

  logic [CountW:0] c_left;
  logic [CountW-1:0] parent;
  logic [CountW-1:0] pos_m1;
  logic [CountW-1:0] cnt_m1;
  logic [15:0] den;
  logic [15:0] frac;
  logic [16:0] sum;
  logic carry;
  logic [15:0] rem_next;
  logic [TimeW-1:0] next_tick_next;
  logic cfg_we;

  tehq_heap_ram u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  tehq_rel_cmp u_cmp (
    .now(now_reg),
    .a  (cmp_a),
    .b  (cmp_b),
    .res(cmp)
  );

  assign busy = (state != S_IDLE);
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_WHOLE:    prdata = {16'd0, tick_whole};
      REG_FRACTION: prdata = {16'd0, tick_fraction};
      REG_DENOM:    prdata = {16'd0, tick_denominator};
      default:      prdata = 32'd0;
    endcase
  end

  always_comb begin
    c_left = {pos, 1'b0};
    parent = pos >> 1;
    pos_m1 = pos - 1'b1;
    cnt_m1 = heap_count - 1'b1;
    den = (tick_denominator == 16'd0) ? 16'd1 : tick_denominator;
    frac = (tick_fraction < den) ? tick_fraction : den - 16'd1;
    sum = {1'b0, tick_remainder} + {1'b0, frac};
    carry = (sum >= {1'b0, den});
    rem_next = carry ? 16'(sum - {1'b0, den}) : sum[15:0];
    next_tick_next = next_tick_time + TimeW'(tick_whole) + TimeW'(carry);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = pos_m1[AddrW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    cmp_a = mem_rdata.expiry;
    cmp_b = key;
    case (state)
      S_UP_RD:    mem_raddr = AddrW'(parent - 1'b1);
      S_UP_CMP:   mem_we = !cmp.le;
      S_DEL_TAIL: mem_raddr = cnt_m1[AddrW-1:0];
      S_DEL_KEY:  mem_raddr = AddrW'(parent - 1'b1);
      S_DEL_PCMP: begin
        cmp_a = key;
        cmp_b = mem_rdata.expiry;
        mem_we = cmp.lt;
      end
      S_DN_RDL:   mem_raddr = AddrW'(c_left - 1'b1);
      S_DN_RDR:   mem_raddr = c_left[AddrW-1:0];
      S_DN_SEL:   cmp_b = child_exp;
      S_DN_CMP: begin
        cmp_a = key;
        cmp_b = child_exp;
        mem_we = !cmp.le;
        mem_wdata = '{expiry: child_exp, owner: child_own};
      end
      S_PLACE: begin
        mem_we = 1'b1;
        mem_wdata = '{expiry: key, owner: key_owner};
      end
      S_TK_CMP:   cmp_b = next_tick_time;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NumHandles; i++) begin
        handle_slot[i] <= '0;
      end
      heap_count <= '0;
      now_reg <= '0;
      next_tick_time <= TimeW'(1);
      tick_remainder <= '0;
      tick_whole <= 16'd1;
      tick_fraction <= 16'd0;
      tick_denominator <= 16'd1;
      strobe <= 1'b0;
      del_mode <= 1'b0;
      in_tick <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_we) begin
        case (paddr[3:2])
          REG_WHOLE: begin
            tick_whole <= pwdata[15:0];
            next_tick_time <= now_reg + TimeW'(pwdata[15:0]);
            tick_remainder <= '0;
          end
          REG_FRACTION: tick_fraction <= pwdata[15:0];
          REG_DENOM: begin
            tick_denominator <= pwdata[15:0];
            tick_remainder <= '0;
          end
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            expired_handle <= '0;
            handle_valid <= 1'b0;
            last <= 1'b1;
            now_time <= now_reg;
            status <= ST_OK;
            in_tick <= 1'b0;
            case (req_type)
              REQ_INSERT: begin
                if (handle_slot[event_handle] != '0) begin
                  status <= ST_QUEUED;
                  strobe <= 1'b1;
                end else if (heap_count >= CountW'(Capacity)) begin
                  status <= ST_FULL;
                  strobe <= 1'b1;
                end else begin
                  heap_count <= heap_count + 1'b1;
                  pos <= heap_count + 1'b1;
                  key <= due_time;
                  key_owner <= event_handle;
                  del_mode <= 1'b0;
                  state <= S_UP_RD;
                end
              end
              REQ_DELETE: begin
                if (handle_slot[event_handle] == '0 ||
                    handle_slot[event_handle] > heap_count) begin
                  status <= ST_NOT_QUEUED;
                  strobe <= 1'b1;
                end else begin
                  pos <= handle_slot[event_handle];
                  del_h <= event_handle;
                  del_mode <= 1'b1;
                  state <= S_DEL_TAIL;
                end
              end
              REQ_TICK: begin
                in_tick <= 1'b1;
                state <= S_TK_RD;
              end
              default: strobe <= 1'b1;
            endcase
          end
        end
        S_UP_RD: begin
          state <= (pos > CountW'(1)) ? S_UP_CMP : S_PLACE;
        end
        S_UP_CMP: begin
          if (cmp.le) begin
            state <= S_PLACE;
          end else begin
            handle_slot[mem_rdata.owner] <= pos;
            pos <= parent;
            state <= S_UP_RD;
          end
        end
        S_DEL_TAIL: state <= S_DEL_KEY;
        S_DEL_KEY: begin
          key <= mem_rdata.expiry;
          key_owner <= mem_rdata.owner;
          heap_count <= cnt_m1;
          if (cnt_m1 == '0) begin
            state <= S_DEL_END;
          end else if (pos > CountW'(1)) begin
            state <= S_DEL_PCMP;
          end else begin
            state <= S_DN_RDL;
          end
        end
        S_DEL_PCMP: begin
          if (cmp.lt) begin
            handle_slot[mem_rdata.owner] <= pos;
            pos <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_DN_RDL;
          end
        end
        S_DN_RDL: begin
          state <= (c_left <= {1'b0, heap_count}) ? S_DN_RDR : S_PLACE;
        end
        S_DN_RDR: begin
          child_exp <= mem_rdata.expiry;
          child_own <= mem_rdata.owner;
          child_idx <= c_left[CountW-1:0];
          state <= (c_left + 1'b1 <= {1'b0, heap_count}) ? S_DN_SEL : S_DN_CMP;
        end
        S_DN_SEL: begin
          if (cmp.lt) begin
            child_exp <= mem_rdata.expiry;
            child_own <= mem_rdata.owner;
            child_idx <= child_idx + 1'b1;
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (cmp.le) begin
            state <= S_PLACE;
          end else begin
            handle_slot[child_own] <= pos;
            pos <= child_idx;
            state <= S_DN_RDL;
          end
        end
        S_PLACE, S_DEL_END: begin
          if (state == S_PLACE) begin
            handle_slot[key_owner] <= pos;
          end
          // The removed handle is cleared last, after any move that named it.
          if (del_mode) begin
            handle_slot[del_h] <= '0;
          end
          if (in_tick) begin
            state <= S_TK_RD;
          end else begin
            strobe <= 1'b1;
            status <= ST_OK;
            state <= S_IDLE;
          end
        end
        S_TK_RD: begin
          state <= (heap_count != '0) ? S_TK_CMP : S_TK_FIN;
        end
        S_TK_CMP: begin
          if (cmp.le) begin
            strobe <= 1'b1;
            status <= ST_OK;
            expired_handle <= mem_rdata.owner;
            handle_valid <= 1'b1;
            last <= 1'b0;
            now_time <= next_tick_time;
            del_h <= mem_rdata.owner;
            del_mode <= 1'b1;
            pos <= CountW'(1);
            state <= S_DEL_TAIL;
          end else begin
            state <= S_TK_FIN;
          end
        end
        S_TK_FIN: begin
          now_reg <= next_tick_time;
          next_tick_time <= next_tick_next;
          tick_remainder <= rem_next;
          strobe <= 1'b1;
          status <= ST_OK;
          expired_handle <= '0;
          handle_valid <= 1'b0;
          last <= 1'b1;
          now_time <= next_tick_time;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- verif/timer_event_heap_queue_tb.sv -----
module timer_event_heap_queue_tb;
  import tehq_pkg::*;

  typedef struct {
    logic [1:0]  req;
    logic [4:0]  handle;
    logic [31:0] etime;
  } request_t;

  typedef struct {
    logic [1:0]  status;
    logic [4:0]  handle;
    logic        valid;
    logic        last;
    logic [31:0] now;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = REQ_INSERT;
  logic [4:0]  event_handle = '0;
  logic [31:0] due_time = '0;
  logic        strobe;
  logic [1:0]  status;
  logic [4:0]  expired_handle;
  logic        handle_valid;
  logic        last;
  logic [31:0] now_time;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  timer_event_heap_queue dut (.*);

  always #5 clk = ~clk;

  // Model of the heap and the tick arithmetic.
  logic [31:0] m_expiry [0:Capacity];
  logic [4:0]  m_owner [0:Capacity];
  logic [5:0]  m_slot [0:NumHandles-1];
  int unsigned m_count;
  logic [31:0] m_now;
  logic [31:0] m_next;
  logic [15:0] m_rem;
  logic [15:0] m_whole;
  logic [15:0] m_frac;
  logic [15:0] m_den;

  request_t pending_reqs[$];
  outcome_t due_beats[$];
  request_t on_port;
  int       idle_pct;
  int       errors = 0;
  int       cycles = 0;

  function automatic logic [31:0] dist_from_now(logic [31:0] t);
    return t - m_now;
  endfunction

  function automatic void place(int dst, int src);
    m_expiry[dst] = m_expiry[src];
    m_owner[dst] = m_owner[src];
    m_slot[m_owner[dst]] = dst[5:0];
  endfunction

  function automatic int climb(int pos, logic [31:0] key);
    int p;
    while (pos > 1) begin
      p = pos >> 1;
      if (dist_from_now(m_expiry[p]) <= dist_from_now(key)) break;
      place(pos, p);
      pos = p;
    end
    return pos;
  endfunction

  function automatic int descend(int pos, logic [31:0] key);
    int c;
    while (pos * 2 <= m_count) begin
      c = pos * 2;
      if (c + 1 <= m_count &&
          dist_from_now(m_expiry[c+1]) < dist_from_now(m_expiry[c]))
        c = c + 1;
      if (dist_from_now(key) <= dist_from_now(m_expiry[c])) break;
      place(pos, c);
      pos = c;
    end
    return pos;
  endfunction

  function automatic void unlink(int pos, logic [4:0] h);
    int tail;
    logic [31:0] key;
    tail = m_count;
    key = m_expiry[tail];
    m_count--;
    if (m_count > 0) begin
      if (pos > 1 && dist_from_now(key) < dist_from_now(m_expiry[pos >> 1])) begin
        place(pos, pos >> 1);
        pos = climb(pos >> 1, key);
      end else begin
        pos = descend(pos, key);
      end
      place(pos, tail);
    end
    m_slot[h] = '0;
  endfunction

  function automatic void model_reset();
    foreach (m_slot[i]) m_slot[i] = '0;
    foreach (m_expiry[i]) begin
      m_expiry[i] = '0;
      m_owner[i] = '0;
    end
    m_count = 0;
    m_now = '0;
    m_next = 32'd1;
    m_rem = '0;
    m_whole = 16'd1;
    m_frac = '0;
    m_den = 16'd1;
  endfunction

  function automatic void model_write(logic [1:0] idx, logic [15:0] v);
    case (idx)
      REG_WHOLE: begin
        m_whole = v;
        m_next = m_now + v;
        m_rem = '0;
      end
      REG_FRACTION: m_frac = v;
      REG_DENOM: begin
        m_den = v;
        m_rem = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_beat(logic [1:0] st, logic [4:0] h, logic v, logic l);
    outcome_t o;
    o.status = st;
    o.handle = h;
    o.valid = v;
    o.last = l;
    o.now = m_now;
    due_beats.push_back(o);
  endfunction

  function automatic void predict_request(request_t r);
    logic [1:0] st;
    int pos;
    logic [4:0] popped[$];
    logic [16:0] den, frac, sum;
    st = ST_OK;
    case (r.req)
      REQ_INSERT: begin
        if (m_slot[r.handle] != 0) st = ST_QUEUED;
        else if (m_count >= Capacity) st = ST_FULL;
        else begin
          m_count++;
          pos = climb(m_count, r.etime);
          m_expiry[pos] = r.etime;
          m_owner[pos] = r.handle;
          m_slot[r.handle] = pos[5:0];
        end
        queue_beat(st, '0, 1'b0, 1'b1);
      end
      REQ_DELETE: begin
        pos = m_slot[r.handle];
        if (pos == 0 || pos > m_count) st = ST_NOT_QUEUED;
        else unlink(pos, r.handle);
        queue_beat(st, '0, 1'b0, 1'b1);
      end
      REQ_TICK: begin
        den = (m_den == 0) ? 17'd1 : {1'b0, m_den};
        frac = ({1'b0, m_frac} < den) ? {1'b0, m_frac} : den - 17'd1;
        while (m_count > 0 && popped.size() < NumHandles &&
               dist_from_now(m_expiry[1]) <= dist_from_now(m_next)) begin
          popped.push_back(m_owner[1]);
          unlink(1, m_owner[1]);
        end
        m_now = m_next;
        sum = {1'b0, m_rem} + frac;
        m_next = m_now + m_whole;
        if (sum >= den) begin
          sum = sum - den;
          m_next = m_next + 1;
        end
        m_rem = sum[15:0];
        foreach (popped[i]) queue_beat(ST_OK, popped[i], 1'b1, 1'b0);
        queue_beat(ST_OK, '0, 1'b0, 1'b1);
      end
      default: queue_beat(ST_OK, '0, 1'b0, 1'b1);
    endcase
  endfunction

  // Driver: presents the next request once the previous one has been taken.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_request(on_port);
      if (!(start && busy)) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          on_port = pending_reqs.pop_front();
          start <= 1'b1;
          req_type <= on_port.req;
          event_handle <= on_port.handle;
          due_time <= on_port.etime;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed beat is checked against the oldest prediction.
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && strobe) begin
      if (due_beats.size() == 0) begin
        $display("%0t: unexpected beat status=%0d handle=%0d valid=%0d last=%0d now=%h",
                 $time, status, expired_handle, handle_valid, last, now_time);
        errors++;
      end else begin
        e = due_beats.pop_front();
        if (status !== e.status) begin
          $display("%0t: status expected %0d got %0d", $time, e.status, status);
          errors++;
        end
        if (expired_handle !== e.handle) begin
          $display("%0t: expired_handle expected %0d got %0d", $time, e.handle,
                   expired_handle);
          errors++;
        end
        if (handle_valid !== e.valid) begin
          $display("%0t: handle_valid expected %0d got %0d", $time, e.valid,
                   handle_valid);
          errors++;
        end
        if (last !== e.last) begin
          $display("%0t: last expected %0d got %0d", $time, e.last, last);
          errors++;
        end
        if (now_time !== e.now) begin
          $display("%0t: now_time expected %h got %h", $time, e.now, now_time);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_req(logic [1:0] rq, logic [4:0] h, logic [31:0] t);
    request_t r;
    r.req = rq;
    r.handle = h;
    r.etime = t;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || start || due_beats.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [15:0] v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    model_write(idx, v);
  endtask

  task automatic random_phase(int n);
    int k;
    logic [1:0] rq;
    logic [31:0] t;
    for (int i = 0; i < n; i++) begin
      while (pending_reqs.size() > 1) @(posedge clk);
      k = $urandom_range(0, 99);
      if (k < 48) rq = REQ_INSERT;
      else if (k < 70) rq = REQ_DELETE;
      else if (k < 95) rq = REQ_TICK;
      else rq = 2'd3;
      // Most expiries fall within a few ticks so that ticks have work to do.
      if ($urandom_range(0, 3) == 0) t = $urandom();
      else t = m_now + $urandom_range(0, 4 * m_whole + 8);
      push_req(rq, 5'($urandom_range(0, 31)), t);
    end
  endtask

  initial begin
    model_reset();
    idle_pct = 30;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    push_req(REQ_INSERT, 5'd0, 32'h0000_0000);
    push_req(REQ_INSERT, 5'd31, 32'hFFFF_FFFF);
    push_req(REQ_INSERT, 5'd31, 32'h0000_0005);
    push_req(REQ_INSERT, 5'd7, 32'h0000_0001);
    push_req(REQ_INSERT, 5'd9, 32'h0000_0003);
    push_req(REQ_INSERT, 5'd10, 32'h0000_0002);
    push_req(REQ_DELETE, 5'd20, 32'h0);
    push_req(REQ_DELETE, 5'd9, 32'h0);
    push_req(REQ_DELETE, 5'd9, 32'hFFFF_FFFF);
    push_req(2'd3, 5'd31, 32'hFFFF_FFFF);
    push_req(REQ_TICK, 5'd0, 32'h0);
    push_req(REQ_TICK, 5'd0, 32'h0);
    push_req(REQ_TICK, 5'd0, 32'h0);
    push_req(REQ_DELETE, 5'd31, 32'h0);
    push_req(REQ_TICK, 5'd0, 32'h0);
    drain();

    // All handles queued and due on one tick.
    for (int h = 0; h < NumHandles; h++) push_req(REQ_INSERT, h[4:0], m_now + 32'd2);
    drain();
    push_req(REQ_INSERT, 5'd3, 32'h0);
    push_req(REQ_TICK, 5'd0, 32'h0);
    push_req(REQ_TICK, 5'd0, 32'h0);
    drain();

    reg_write(REG_WHOLE, 16'd20);
    reg_write(REG_FRACTION, 16'd3);
    reg_write(REG_DENOM, 16'd7);
    random_phase(45);
    drain();

    idle_pct = 56;
    reg_write(REG_WHOLE, 16'hFFFF);
    reg_write(REG_FRACTION, 16'hFFFF);
    reg_write(REG_DENOM, 16'hFFFF);
    random_phase(45);
    drain();

    idle_pct = 0;
    reg_write(REG_DENOM, 16'd0);
    reg_write(REG_FRACTION, 16'd0);
    reg_write(REG_WHOLE, 16'd0);
    random_phase(20);
    drain();
    reg_write(REG_WHOLE, 16'd5);
    reg_write(REG_FRACTION, 16'd9);
    reg_write(REG_DENOM, 16'd4);
    random_phase(50);
    drain();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/tehq_pkg.sv
src/tehq_heap_ram.sv
src/tehq_rel_cmp.sv
src/timer_event_heap_queue.sv
verif/timer_event_heap_queue_tb.sv
